// File: sv/hct_pkg.sv
// ----------------------------------------------------------------------------
// hct_pkg
// Shared types, constants and commutation tables for the hall commutation
// and tacho unit.
// ----------------------------------------------------------------------------
package hct_pkg;

   localparam int unsigned HALL_W  = 3;
   localparam int unsigned DUTY_W  = 16;
   localparam int unsigned LEVEL_W = 12;
   localparam int unsigned TACHO_W = 32;
   localparam int unsigned MAP_W   = 24;
   localparam int unsigned WRAP_W  = 16;
   localparam int unsigned MAG_W   = DUTY_W + 1;
   localparam int unsigned PROD_W  = MAG_W + WRAP_W;
   localparam int unsigned FRAC_W  = 15;

   localparam logic [2:0] LOW_OFF = 3'b111;

   // csr register indexes
   localparam logic CSR_HALL_MAP        = 1'b0;
   localparam logic CSR_SETTINGS_LOADED = 1'b1;

   // phase index of the PWM high side
   localparam logic [1:0] PHASE_U = 2'd0;
   localparam logic [1:0] PHASE_V = 2'd1;
   localparam logic [1:0] PHASE_W = 2'd2;

   typedef struct packed {
      logic [HALL_W-1:0]        hall_bits;
      logic signed [DUTY_W-1:0] duty_q15;
      logic                     fault_active;
   } hct_item_type;

   typedef struct packed {
      logic [MAP_W-1:0] hall_map;
      logic             settings_loaded;
   } hct_cfg_type;

   function automatic logic [1:0] high_phase(input logic [2:0] step);
      logic [1:0] ph;
      case (step)
         3'd1: ph = PHASE_V;
         3'd2: ph = PHASE_W;
         3'd3: ph = PHASE_W;
         3'd4: ph = PHASE_U;
         3'd5: ph = PHASE_U;
         3'd6: ph = PHASE_V;
         default: ph = PHASE_U;
      endcase
      return ph;
   endfunction

   function automatic logic [2:0] low_pin(input logic [2:0] step);
      logic [2:0] pin;
      case (step)
         3'd1: pin = 3'b001;
         3'd2: pin = 3'b001;
         3'd3: pin = 3'b010;
         3'd4: pin = 3'b010;
         3'd5: pin = 3'b100;
         3'd6: pin = 3'b100;
         default: pin = LOW_OFF;
      endcase
      return pin;
   endfunction

endpackage

// File: sv/hct_input_stage.sv
// ----------------------------------------------------------------------------
// hct_input_stage
// Input register: captures one request and holds it until the commutation
// stage takes it.
// ----------------------------------------------------------------------------
module hct_input_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  hct_pkg::hct_item_type req_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hct_pkg::hct_item_type out_item
);

   logic                  valid_ff;
   logic                  valid_in;
   hct_pkg::hct_item_type item_ff;

   assign req_ready = !valid_ff || out_ready;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// File: sv/hct_commutator.sv
// ----------------------------------------------------------------------------
// hct_commutator
// Step lookup, PWM level, low-side mask and tacho update; the state
// registers double as the response register.
// ----------------------------------------------------------------------------
module hct_commutator #(
   parameter int unsigned PWM_WRAP = 3299
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hct_pkg::hct_cfg_type          cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  hct_pkg::hct_item_type         in_item,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [hct_pkg::LEVEL_W-1:0]   rsp_level_u,
   output logic [hct_pkg::LEVEL_W-1:0]   rsp_level_v,
   output logic [hct_pkg::LEVEL_W-1:0]   rsp_level_w,
   output logic [2:0]                    rsp_low_side_mask,
   output logic [hct_pkg::TACHO_W-1:0]   rsp_tacho_count,
   output logic [hct_pkg::TACHO_W-1:0]   rsp_tacho_total,
   output logic                          rsp_spin_direction,
   output logic                          rsp_hall_invalid,
   output logic                          rsp_step_error
);

   localparam logic [hct_pkg::WRAP_W-1:0] WRAP = hct_pkg::WRAP_W'(PWM_WRAP);

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [hct_pkg::HALL_W-1:0]      prev_hall_ff, prev_hall_in;
   logic                            prev_hall_valid_ff, prev_hall_valid_in;
   logic [2:0]                      prev_step_ff, prev_step_in;
   logic                            prev_step_valid_ff, prev_step_valid_in;
   logic [hct_pkg::DUTY_W-1:0]      prev_duty_ff, prev_duty_in;
   logic                            prev_duty_valid_ff, prev_duty_valid_in;
   logic [hct_pkg::TACHO_W-1:0]     tacho_ff, tacho_in;
   logic [hct_pkg::TACHO_W-1:0]     tacho_abs_ff, tacho_abs_in;
   logic                            dir_ff, dir_in;
   logic                            invalid_ff, invalid_in;
   logic                            error_ff, error_in;
   logic [hct_pkg::LEVEL_W-1:0]     drive_ff [3];
   logic [hct_pkg::LEVEL_W-1:0]     drive_in [3];
   logic [2:0]                      low_mask_ff, low_mask_in;

   logic                            advance;
   logic                            negative;
   logic                            hall_changed;
   logic                            duty_changed;
   logic [2:0]                      map_idx;
   logic [2:0]                      step;
   logic [hct_pkg::MAG_W-1:0]       mag;
   logic [hct_pkg::PROD_W-1:0]      product;
   logic [hct_pkg::LEVEL_W-1:0]     level;
   logic                            drive_off;
   logic signed [3:0]               diff_raw;
   logic signed [3:0]               diff;
   logic [1:0]                      diff_abs;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign advance  = in_valid && in_ready;
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_comb begin
      negative     = in_item.duty_q15[hct_pkg::DUTY_W-1];
      hall_changed = !prev_hall_valid_ff || (prev_hall_ff != in_item.hall_bits);
      duty_changed = !prev_duty_valid_ff || (prev_duty_ff != in_item.duty_q15);
      map_idx      = negative ? in_item.hall_bits : ~in_item.hall_bits;
      step         = cfg.hall_map[5'(map_idx) * 5'd3 +: 3];

      mag = negative ? (hct_pkg::MAG_W'(0) - {1'b1, in_item.duty_q15})
                     : {1'b0, in_item.duty_q15};
      product = hct_pkg::PROD_W'(mag) * hct_pkg::PROD_W'(WRAP);
      level   = product[hct_pkg::FRAC_W +: hct_pkg::LEVEL_W];

      drive_off = (in_item.duty_q15 == '0) || in_item.fault_active
                  || !cfg.settings_loaded;

      // prev_step - step, folded into -3..3
      diff_raw = $signed({1'b0, prev_step_ff}) - $signed({1'b0, step});
      if (diff_raw < -4'sd3) begin
         diff = diff_raw + 4'sd6;
      end else if (diff_raw > 4'sd3) begin
         diff = diff_raw - 4'sd6;
      end else begin
         diff = diff_raw;
      end
      diff_abs = diff[3] ? 2'(-diff) : diff[1:0];

      prev_hall_in       = prev_hall_ff;
      prev_hall_valid_in = prev_hall_valid_ff;
      prev_step_in       = prev_step_ff;
      prev_step_valid_in = prev_step_valid_ff;
      prev_duty_in       = prev_duty_ff;
      prev_duty_valid_in = prev_duty_valid_ff;
      tacho_in           = tacho_ff;
      tacho_abs_in       = tacho_abs_ff;
      dir_in             = dir_ff;
      invalid_in         = invalid_ff;
      error_in           = error_ff;
      drive_in           = drive_ff;
      low_mask_in        = low_mask_ff;

      if (advance && (hall_changed || duty_changed)) begin
         if (step == 3'd0 || step == 3'd7) begin
            invalid_in = 1'b1;
         end else begin
            invalid_in  = 1'b0;
            drive_in[0] = '0;
            drive_in[1] = '0;
            drive_in[2] = '0;
            if (drive_off) begin
               low_mask_in = hct_pkg::LOW_OFF;
            end else begin
               drive_in[hct_pkg::high_phase(step)] = level;
               low_mask_in = hct_pkg::low_pin(step);
            end
            if (hall_changed && prev_step_valid_ff) begin
               if (diff >= -4'sd3 && diff <= 4'sd3) begin
                  tacho_in     = tacho_ff + {{(hct_pkg::TACHO_W-4){diff[3]}}, diff};
                  tacho_abs_in = tacho_abs_ff + hct_pkg::TACHO_W'(diff_abs);
                  dir_in       = (diff > 4'sd0);
               end else begin
                  error_in = 1'b1;
               end
            end
            prev_step_in       = step;
            prev_step_valid_in = 1'b1;
            prev_hall_in       = in_item.hall_bits;
            prev_hall_valid_in = 1'b1;
            prev_duty_in       = in_item.duty_q15;
            prev_duty_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff       <= 1'b0;
         prev_hall_ff       <= '0;
         prev_hall_valid_ff <= 1'b0;
         prev_step_ff       <= '0;
         prev_step_valid_ff <= 1'b0;
         prev_duty_ff       <= '0;
         prev_duty_valid_ff <= 1'b0;
         tacho_ff           <= '0;
         tacho_abs_ff       <= '0;
         dir_ff             <= 1'b0;
         invalid_ff         <= 1'b0;
         error_ff           <= 1'b0;
         drive_ff[0]        <= '0;
         drive_ff[1]        <= '0;
         drive_ff[2]        <= '0;
         low_mask_ff        <= hct_pkg::LOW_OFF;
      end else begin
         rsp_valid_ff       <= rsp_valid_in;
         prev_hall_ff       <= prev_hall_in;
         prev_hall_valid_ff <= prev_hall_valid_in;
         prev_step_ff       <= prev_step_in;
         prev_step_valid_ff <= prev_step_valid_in;
         prev_duty_ff       <= prev_duty_in;
         prev_duty_valid_ff <= prev_duty_valid_in;
         tacho_ff           <= tacho_in;
         tacho_abs_ff       <= tacho_abs_in;
         dir_ff             <= dir_in;
         invalid_ff         <= invalid_in;
         error_ff           <= error_in;
         drive_ff           <= drive_in;
         low_mask_ff        <= low_mask_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_level_u        = drive_ff[0];
   assign rsp_level_v        = drive_ff[1];
   assign rsp_level_w        = drive_ff[2];
   assign rsp_low_side_mask  = low_mask_ff;
   assign rsp_tacho_count    = tacho_ff;
   assign rsp_tacho_total    = tacho_abs_ff;
   assign rsp_spin_direction = dir_ff;
   assign rsp_hall_invalid   = invalid_ff;
   assign rsp_step_error     = error_ff;

endmodule

// File: sv/hall_commutation_tacho_unit.sv
// Path: a request passes the input register, then commutation and tacho update into
// the state register, which drives the response.
// Throughput: one request per cycle while rsp_ready is high; low rsp_ready stalls it.
// Reset: synchronous; clears csr registers, tacho and history, levels to 0,
// low-side mask to all phases off.
// ----------------------------------------------------------------------------
// hall_commutation_tacho_unit
// Six-step hall commutation with signed and absolute tacho counters.
// ----------------------------------------------------------------------------
module hall_commutation_tacho_unit #(
   parameter int unsigned PWM_WRAP = 3299
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic                               csr_index,
   input  logic [hct_pkg::MAP_W-1:0]          csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [hct_pkg::HALL_W-1:0]         req_hall_bits,
   input  logic signed [hct_pkg::DUTY_W-1:0]  req_duty_q15,
   input  logic                               req_fault_active,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [hct_pkg::LEVEL_W-1:0]        rsp_level_u,
   output logic [hct_pkg::LEVEL_W-1:0]        rsp_level_v,
   output logic [hct_pkg::LEVEL_W-1:0]        rsp_level_w,
   output logic [2:0]                         rsp_low_side_mask,
   output logic [hct_pkg::TACHO_W-1:0]        rsp_tacho_count,
   output logic [hct_pkg::TACHO_W-1:0]        rsp_tacho_total,
   output logic                               rsp_spin_direction,
   output logic                               rsp_hall_invalid,
   output logic                               rsp_step_error
);

   hct_pkg::hct_cfg_type  cfg_ff;
   hct_pkg::hct_item_type req_item;
   hct_pkg::hct_item_type s1_item;
   logic                  s1_valid;
   logic                  s1_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            hct_pkg::CSR_HALL_MAP:        cfg_ff.hall_map <= csr_wdata;
            hct_pkg::CSR_SETTINGS_LOADED: cfg_ff.settings_loaded <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign req_item.hall_bits    = req_hall_bits;
   assign req_item.duty_q15     = req_duty_q15;
   assign req_item.fault_active = req_fault_active;

   hct_input_stage u_input (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_item  (s1_item)
   );

   hct_commutator #(
      .PWM_WRAP (PWM_WRAP)
   ) u_commutator (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .in_valid           (s1_valid),
      .in_ready           (s1_ready),
      .in_item            (s1_item),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_level_u        (rsp_level_u),
      .rsp_level_v        (rsp_level_v),
      .rsp_level_w        (rsp_level_w),
      .rsp_low_side_mask  (rsp_low_side_mask),
      .rsp_tacho_count    (rsp_tacho_count),
      .rsp_tacho_total    (rsp_tacho_total),
      .rsp_spin_direction (rsp_spin_direction),
      .rsp_hall_invalid   (rsp_hall_invalid),
      .rsp_step_error     (rsp_step_error)
   );

   // low side is either fully off or exactly one pin
   a_low_mask_shape: assert property (@(posedge clock) disable iff (reset)
      $onehot(rsp_low_side_mask) || (rsp_low_side_mask == hct_pkg::LOW_OFF))
      else $error("low-side mask has more than one active pin");

   // at most one high side carries a PWM level
   a_one_high_side: assert property (@(posedge clock) disable iff (reset)
      $countones({rsp_level_u != '0, rsp_level_v != '0, rsp_level_w != '0}) <= 1)
      else $error("more than one high side driven");

   // phases off means no high-side level either
   a_off_means_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_low_side_mask == hct_pkg::LOW_OFF) |->
      (rsp_level_u == '0 && rsp_level_v == '0 && rsp_level_w == '0))
      else $error("high side driven while phases off");

   // folded step difference always lies in -3..3
   a_no_step_error: assert property (@(posedge clock) disable iff (reset)
      !rsp_step_error)
      else $error("step difference out of range");

   // absolute tacho moves by at most three per request
   a_tacho_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(rsp_tacho_total) |-> (rsp_tacho_total - $past(rsp_tacho_total)) <= 32'd3)
      else $error("absolute tacho jumped by more than three");

endmodule
